FILE: hdl/psc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_pkg: shared types and constants for the polygon slab clipper
// Holds the transaction payload structs, the controller command and status
// structs, register indexes and the result select codes.
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam int COORD_W  = 32;
    localparam int INDEX_W  = 6;
    localparam int DIV_STEPS = 32;
    localparam int STEP_W   = 5;

    // Largest polygon the block is expected to see.
    localparam int MAX_VERTS = 16;

    localparam logic [INDEX_W-1:0] COUNT_MAX = 6'd63;

    // Configuration register indexes.
    localparam logic [1:0] REG_AXIS  = 2'd0;
    localparam logic [1:0] REG_MODE  = 2'd1;
    localparam logic [1:0] REG_LOWER = 2'd2;
    localparam logic [1:0] REG_UPPER = 2'd3;

    // Axis codes; the two unused codes select z.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    // Result select codes.
    localparam logic [1:0] SEL_CROSS  = 2'd0;
    localparam logic [1:0] SEL_VERTEX = 2'd1;
    localparam logic [1:0] SEL_MARKER = 2'd2;

    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic                      polygon_end;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      valid_res;
        logic [INDEX_W-1:0]        out_index;
        logic                      last_of_run;
        logic                      polygon_done;
    } out_item_t;

    typedef struct packed {
        logic       load;
        logic       mul;
        logic       div;
        logic       store;
        logic       emit;
        logic [1:0] emit_sel;
        logic       last;
        logic [1:0] coord;
        logic       bound_sel;
    } cmd_t;

    typedef struct packed {
        logic [1:0] ncross;
        logic       keep;
        logic       poly_end;
        logic       out_free;
    } status_t;

endpackage

FILE: hdl/polygon_slab_clipper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_slab_clipper: one-slab polygon clipper
// Clips a streamed polygon edge loop against lower_bound..upper_bound along a
// chosen axis, emitting interpolated crossings and kept vertices.
// ----------------------------------------------------------------------------
//  Channel  Handshake             Payload     Role
//  src      src_valid/src_ready   src_item    vertex transactions in
//  res      res_valid/res_ready   res_item    result transactions out
//  cfg      cfg_valid/cfg_ready   cfg_index,  register writes, always ready
//                                 cfg_data
//
// A priming transaction is only accepted. A vertex is accepted and decided,
// then for each crossing runs, for each of the three coordinates, a multiply,
// the restoring divide steps and a store, then an emit and a new decide; a
// kept vertex or an end marker adds one more emit. The single shared
// restoring divider dominates this work. Reset clears the configuration
// registers, the previous vertex and the output count. A stalled result holds
// in the output register; the next vertex transaction is still accepted while
// it waits, and work pauses only when a further result must be written.
// ----------------------------------------------------------------------------
module polygon_slab_clipper (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_ready,
    input  psc_pkg::in_item_t   src_item,
    output logic                res_valid,
    input  logic                res_ready,
    output psc_pkg::out_item_t  res_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    psc_pkg::cmd_t    cmd;
    psc_pkg::status_t status;

    // Registers are to be written by the user while the block is idle (not enforced here); the port never stalls.
    assign cfg_ready = 1'b1;

    psc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_kind  (src_item.kind),
        .src_ready (src_ready),
        .status    (status),
        .cmd       (cmd)
    );

    psc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src_item  (src_item),
        .cmd       (cmd),
        .status    (status),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

endmodule

FILE: hdl/psc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_ctrl: sequencing state machine
// Steps each vertex through its crossings, coordinate by coordinate, and
// issues the result emits in order.
// ----------------------------------------------------------------------------
module psc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    input  logic              src_kind,
    output logic              src_ready,
    input  psc_pkg::status_t  status,
    output psc_pkg::cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_STORE  = 3'd4;
    localparam logic [2:0] ST_EMIT_C = 3'd5;
    localparam logic [2:0] ST_EMIT_V = 3'd6;
    localparam logic [2:0] ST_EMIT_M = 3'd7;

    logic [2:0]                 state_reg, state_next;
    logic [1:0]                 k_reg, k_next;
    logic [1:0]                 xi_reg, xi_next;
    logic [psc_pkg::STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= 2'd0;
            xi_reg    <= 2'd0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            xi_reg    <= xi_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        xi_next       = xi_reg;
        step_next     = step_reg;
        src_ready     = 1'b0;
        cmd           = '0;
        cmd.coord     = k_reg;
        cmd.bound_sel = xi_reg[0];
        case (state_reg)
            ST_IDLE:
            begin
                src_ready = 1'b1;
                if (src_valid)
                begin
                    cmd.load = 1'b1;
                    xi_next  = 2'd0;
                    if (src_kind)
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE:
            begin
                if (xi_reg < status.ncross)
                begin
                    k_next     = 2'd0;
                    state_next = ST_MUL;
                end
                else if (status.keep)
                begin
                    state_next = ST_EMIT_V;
                end
                else if (status.poly_end && status.ncross == 2'd0)
                begin
                    state_next = ST_EMIT_M;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div = 1'b1;
                if (step_reg == psc_pkg::STEP_W'(psc_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_STORE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                if (k_reg == 2'd2)
                begin
                    state_next = ST_EMIT_C;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_EMIT_C:
            begin
                if (status.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = psc_pkg::SEL_CROSS;
                    cmd.last     = (xi_reg + 1'b1 == status.ncross) && !status.keep;
                    xi_next      = xi_reg + 1'b1;
                    state_next   = ST_DECIDE;
                end
            end
            ST_EMIT_V:
            begin
                if (status.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = psc_pkg::SEL_VERTEX;
                    cmd.last     = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_EMIT_M:
            begin
                if (status.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = psc_pkg::SEL_MARKER;
                    cmd.last     = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/psc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_dp: clipper datapath
// Configuration registers, vertex state, crossing plan, one multiplier, a
// shared restoring divider and the output register.
// ----------------------------------------------------------------------------
module psc_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  psc_pkg::in_item_t   src_item,
    input  psc_pkg::cmd_t       cmd,
    output psc_pkg::status_t    status,
    output logic                res_valid,
    input  logic                res_ready,
    output psc_pkg::out_item_t  res_item
);

    localparam int W = psc_pkg::COORD_W;

    logic [1:0]              axis_reg;
    logic                    mode_reg;
    logic signed [W-1:0]     lo_reg, hi_reg;
    logic [2:0][W-1:0]       prev_reg, v_reg, p_reg, cross_reg;
    logic signed [W-1:0]     c_reg, pc_reg;
    logic [1:0][W-1:0]       b_reg;
    logic [1:0]              ncross_reg;
    logic                    keep_reg, end_reg;
    logic [psc_pkg::INDEX_W-1:0] count_reg, count_next;
    logic [W-1:0]            den_reg, rem_reg, quo_reg;
    logic                    neg_reg;
    logic                    out_valid_reg;
    psc_pkg::out_item_t      out_reg, out_next;

    // Crossing plan for the incoming vertex.
    logic signed [W-1:0] vc, pcv, hi_eff;
    logic [1:0]          pl_n;
    logic [1:0][W-1:0]   pl_b;
    logic                pl_keep;

    always_comb
    begin
        case (axis_reg)
            psc_pkg::AXIS_X:
            begin
                vc  = src_item.pos_x;
                pcv = prev_reg[0];
            end
            psc_pkg::AXIS_Y:
            begin
                vc  = src_item.pos_y;
                pcv = prev_reg[1];
            end
            default:
            begin
                vc  = src_item.pos_z;
                pcv = prev_reg[2];
            end
        endcase
        hi_eff  = (hi_reg < lo_reg) ? lo_reg : hi_reg;
        pl_n    = 2'd0;
        pl_b    = '0;
        pl_keep = 1'b1;
        if (vc < lo_reg)
        begin
            pl_keep = mode_reg;
            if (pcv > hi_eff)
            begin
                pl_b[0] = hi_eff;
                pl_b[1] = lo_reg;
                pl_n    = 2'd2;
            end
            else if (pcv > lo_reg)
            begin
                pl_b[0] = lo_reg;
                pl_n    = 2'd1;
            end
        end
        else if (vc > hi_eff)
        begin
            pl_keep = mode_reg;
            if (pcv < lo_reg)
            begin
                pl_b[0] = lo_reg;
                pl_b[1] = hi_eff;
                pl_n    = 2'd2;
            end
            else if (pcv < hi_eff)
            begin
                pl_b[0] = hi_eff;
                pl_n    = 2'd1;
            end
        end
        else
        begin
            if (pcv < lo_reg)
            begin
                if (vc > lo_reg)
                begin
                    pl_b[0] = lo_reg;
                    pl_n    = 2'd1;
                end
            end
            else if (pcv > hi_eff && vc < hi_eff)
            begin
                pl_b[0] = hi_eff;
                pl_n    = 2'd1;
            end
        end
    end

    // Operand magnitudes and the product for one coordinate of a crossing.
    logic signed [W:0] d_s, num_s, den_s;
    logic [W:0]        d_a, num_a, den_a;
    logic [2*W-1:0]    prod;

    always_comb
    begin
        d_s   = {p_reg[cmd.coord][W-1], p_reg[cmd.coord]}
              - {v_reg[cmd.coord][W-1], v_reg[cmd.coord]};
        num_s = {b_reg[cmd.bound_sel][W-1], b_reg[cmd.bound_sel]} - {c_reg[W-1], c_reg};
        den_s = {pc_reg[W-1], pc_reg} - {c_reg[W-1], c_reg};
        d_a   = d_s[W]   ? -d_s   : d_s;
        num_a = num_s[W] ? -num_s : num_s;
        den_a = den_s[W] ? -den_s : den_s;
        prod  = d_a[W-1:0] * num_a[W-1:0];
    end

    // One restoring division step.
    logic [W:0] rem2, rem_sub;
    logic       ge;

    always_comb
    begin
        rem2    = {rem_reg, quo_reg[W-1]};
        rem_sub = rem2 - {1'b0, den_reg};
        ge      = (rem2 >= {1'b0, den_reg});
    end

    logic [W:0] sum;

    always_comb
    begin
        sum = neg_reg ? ({v_reg[cmd.coord][W-1], v_reg[cmd.coord]} - {1'b0, quo_reg})
                      : ({v_reg[cmd.coord][W-1], v_reg[cmd.coord]} + {1'b0, quo_reg});
    end

    // Result assembly.
    logic out_free, done;

    always_comb
    begin
        out_free = !out_valid_reg || res_ready;
        done     = end_reg && cmd.last;
        out_next = '0;
        case (cmd.emit_sel)
            psc_pkg::SEL_CROSS:
            begin
                out_next.out_x     = cross_reg[0];
                out_next.out_y     = cross_reg[1];
                out_next.out_z     = cross_reg[2];
                out_next.valid_res = 1'b1;
            end
            psc_pkg::SEL_VERTEX:
            begin
                out_next.out_x     = v_reg[0];
                out_next.out_y     = v_reg[1];
                out_next.out_z     = v_reg[2];
                out_next.valid_res = 1'b1;
            end
            default:
            begin
                out_next.valid_res = 1'b0;
            end
        endcase
        out_next.out_index    = count_reg;
        out_next.last_of_run  = cmd.last;
        out_next.polygon_done = done;
        if (done)
        begin
            count_next = '0;
        end
        else if (count_reg < psc_pkg::COUNT_MAX)
        begin
            count_next = count_reg + 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg      <= 2'd0;
            mode_reg      <= 1'b0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            prev_reg      <= '0;
            count_reg     <= '0;
            ncross_reg    <= 2'd0;
            keep_reg      <= 1'b0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    psc_pkg::REG_AXIS:  axis_reg <= cfg_data[1:0];
                    psc_pkg::REG_MODE:  mode_reg <= cfg_data[0];
                    psc_pkg::REG_LOWER: lo_reg   <= cfg_data;
                    psc_pkg::REG_UPPER: hi_reg   <= cfg_data;
                    default:            axis_reg <= axis_reg;
                endcase
            end
            if (cmd.load)
            begin
                prev_reg <= {src_item.pos_z, src_item.pos_y, src_item.pos_x};
                if (!src_item.kind)
                begin
                    count_reg <= '0;
                end
                ncross_reg <= pl_n;
                keep_reg   <= pl_keep;
                end_reg    <= src_item.polygon_end;
            end
            if (cmd.emit)
            begin
                count_reg <= count_next;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            v_reg  <= {src_item.pos_z, src_item.pos_y, src_item.pos_x};
            p_reg  <= prev_reg;
            c_reg  <= vc;
            pc_reg <= pcv;
            b_reg  <= pl_b;
        end
        if (cmd.mul)
        begin
            rem_reg <= prod[2*W-1:W];
            quo_reg <= prod[W-1:0];
            den_reg <= den_a[W-1:0];
            neg_reg <= d_s[W] ^ num_s[W] ^ den_s[W];
        end
        if (cmd.div)
        begin
            rem_reg <= ge ? rem_sub[W-1:0] : rem2[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ge};
        end
        if (cmd.store)
        begin
            cross_reg[cmd.coord] <= sum[W-1:0];
        end
        if (cmd.emit)
        begin
            out_reg <= out_next;
        end
    end

    assign status.ncross   = ncross_reg;
    assign status.keep     = keep_reg;
    assign status.poly_end = end_reg;
    assign status.out_free = out_free;
    assign res_valid       = out_valid_reg;
    assign res_item        = out_reg;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the polygon slab clipper
// Streams priming and vertex transactions, predicts every slab crossing and
// kept vertex in-bench, and compares each result transaction field by field.
// A directed table comes first, then random polygons under several settings.
// ----------------------------------------------------------------------------
module tb;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               src_valid = 1'b0;
    logic               src_ready;
    psc_pkg::in_item_t  src_item = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    psc_pkg::out_item_t res_item;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    polygon_slab_clipper u_top (
        .clk(clk), .rst_n(rst_n),
        .src_valid(src_valid), .src_ready(src_ready), .src_item(src_item),
        .res_valid(res_valid), .res_ready(res_ready), .res_item(res_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Settling allowance after the last result, so that a vertex whose only
    // effect is state has finished.
    localparam int DRAIN_CYCLES = 260;

    // Bench copy of the block's registers and state.
    logic [1:0]  slab_axis;
    logic        slab_mode;
    logic signed [31:0] slab_lo, slab_hi;
    logic signed [31:0] last_x, last_y, last_z;
    logic [5:0]  emitted;

    psc_pkg::out_item_t expected_q[$];
    int                 fail_count = 0;

    // One directed row: the transaction and, optionally, typed-in results.
    typedef struct {
        psc_pkg::in_item_t  item;
        int                 n_typed;
        psc_pkg::out_item_t typed[3];
    } dir_row_t;

    task automatic report_mismatch(input string what, input psc_pkg::out_item_t got,
                                   input psc_pkg::out_item_t want);
        fail_count++;
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    // Interpolated coordinate: vk + trunc((pk - vk) * num / den), exact in 64 bits.
    function automatic logic signed [31:0] interp(input longint vk, input longint pk,
                                                   input longint num, input longint den);
        longint unsigned dm, nm, qm, um;
        longint d;
        bit neg;
        d = pk - vk;
        um = (den < 0) ? -den : den;
        if (um == 0)
            return vk[31:0];
        dm = (d < 0) ? -d : d;
        nm = (num < 0) ? -num : num;
        qm = dm * nm / um;
        neg = ((d < 0) != (num < 0)) != (den < 0);
        return neg ? 32'(vk - longint'(qm)) : 32'(vk + longint'(qm));
    endfunction

    // Works out the results of one vertex transaction and updates the state.
    task automatic predict_clip(input psc_pkg::in_item_t it,
                                output psc_pkg::out_item_t res[$]);
        longint v[3], p[3], lo, hi, c, pc, b;
        longint bounds[$];
        bit keep;
        psc_pkg::out_item_t r;
        res = {};
        v[0] = it.pos_x; v[1] = it.pos_y; v[2] = it.pos_z;
        if (!it.kind)
        begin
            last_x = it.pos_x; last_y = it.pos_y; last_z = it.pos_z;
            emitted = '0;
            return;
        end
        p[0] = last_x; p[1] = last_y; p[2] = last_z;
        lo = slab_lo;
        hi = slab_hi;
        if (hi < lo)
            hi = lo;
        c  = (slab_axis == psc_pkg::AXIS_X) ? v[0] : (slab_axis == psc_pkg::AXIS_Y) ? v[1] : v[2];
        pc = (slab_axis == psc_pkg::AXIS_X) ? p[0] : (slab_axis == psc_pkg::AXIS_Y) ? p[1] : p[2];
        if (c < lo)
        begin
            if (pc > hi) bounds.push_back(hi);
            if (pc > lo) bounds.push_back(lo);
            keep = slab_mode;
        end
        else if (c > hi)
        begin
            if (pc < lo) bounds.push_back(lo);
            if (pc < hi) bounds.push_back(hi);
            keep = slab_mode;
        end
        else
        begin
            if (pc < lo)
            begin
                if (c > lo) bounds.push_back(lo);
            end
            else if (pc > hi && c < hi)
            begin
                bounds.push_back(hi);
            end
            keep = 1'b1;
        end
        foreach (bounds[i])
        begin
            b = bounds[i];
            r = '0;
            r.out_x = interp(v[0], p[0], b - c, pc - c);
            r.out_y = interp(v[1], p[1], b - c, pc - c);
            r.out_z = interp(v[2], p[2], b - c, pc - c);
            r.valid_res = 1'b1;
            res.push_back(r);
        end
        if (keep)
        begin
            r = '0;
            r.out_x = it.pos_x; r.out_y = it.pos_y; r.out_z = it.pos_z;
            r.valid_res = 1'b1;
            res.push_back(r);
        end
        last_x = it.pos_x; last_y = it.pos_y; last_z = it.pos_z;
        foreach (res[i])
        begin
            res[i].out_index = emitted;
            res[i].last_of_run = (i == res.size() - 1);
            res[i].polygon_done = it.polygon_end && (i == res.size() - 1);
            if (emitted < psc_pkg::COUNT_MAX)
                emitted++;
        end
        if (res.size() == 0 && it.polygon_end)
        begin
            r = '0;
            r.out_index = emitted;
            r.last_of_run = 1'b1;
            r.polygon_done = 1'b1;
            res.push_back(r);
        end
        if (it.polygon_end)
            emitted = '0;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            psc_pkg::REG_AXIS:  slab_axis = val[1:0];
            psc_pkg::REG_MODE:  slab_mode = val[0];
            psc_pkg::REG_LOWER: slab_lo = val;
            default:            slab_hi = val;
        endcase
    endtask

    // Presents one transaction after the given gap and returns at the edge that
    // accepts it. Valid is dropped only when a gap follows, so a transaction
    // that comes straight after takes over the same cycle.
    task automatic drive_item(input psc_pkg::in_item_t it, input int gap);
        if (gap != 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_item  <= it;
        do @(posedge clk); while (!src_ready);
    endtask

    // Sends one transaction after a random gap, or none when quiet; expectations are queued first
    // so a fast result always finds its entry waiting.
    task automatic send_vertex(input psc_pkg::in_item_t it, input bit quiet);
        psc_pkg::out_item_t res[$];
        int gap;
        gap = quiet ? 0 : int'($urandom_range(0, 10));
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        predict_clip(it, res);
        foreach (res[i])
            expected_q.push_back(res[i]);
        drive_item(it, gap);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        src_valid <= 1'b0;
        while (expected_q.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_coord(input logic signed [31:0] lo,
                                                      input logic signed [31:0] hi);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return $urandom();
        if (pick == 1)
            return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
        // Mostly land around the slab so crossings are common.
        return lo + $signed($urandom_range(0, 4096)) - 32'sd2048
               + (($urandom_range(0, 1) != 0) ? (hi - lo) : 32'sd0);
    endfunction

    function automatic psc_pkg::in_item_t mk(input bit k, input logic [31:0] x,
                                             input logic [31:0] y, input logic [31:0] z,
                                             input bit e);
        psc_pkg::in_item_t it;
        it.kind = k; it.pos_x = x; it.pos_y = y; it.pos_z = z; it.polygon_end = e;
        return it;
    endfunction

    // Result sink with random stalls, including runs with none.
    initial
    begin : result_sink
        int stall;
        psc_pkg::out_item_t want;
        forever
        begin
            stall = ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(0, 10));
            if (stall != 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected", res_item, '0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (res_item.out_x !== want.out_x) report_mismatch("out_x", res_item, want);
                if (res_item.out_y !== want.out_y) report_mismatch("out_y", res_item, want);
                if (res_item.out_z !== want.out_z) report_mismatch("out_z", res_item, want);
                if (res_item.valid_res !== want.valid_res)
                    report_mismatch("valid_res", res_item, want);
                if (res_item.out_index !== want.out_index)
                    report_mismatch("out_index", res_item, want);
                if (res_item.last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", res_item, want);
                if (res_item.polygon_done !== want.polygon_done)
                    report_mismatch("polygon_done", res_item, want);
            end
        end
    end

    initial
    begin : watchdog
        #20ms;
        $display("FAIL polygon_slab_clipper");
        $finish;
    end

    initial
    begin : stimulus
        dir_row_t           rows[$];
        dir_row_t           row;
        psc_pkg::out_item_t res[$];
        int nverts, sent;
        logic signed [31:0] lo, hi;

        slab_axis = '0; slab_mode = 1'b0; slab_lo = '0; slab_hi = '0;
        last_x = '0; last_y = '0; last_z = '0; emitted = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table. Rows with n_typed set carry results read straight off
        // the behaviour after reset; the rest rely on the predictor.
        // After reset the slab is the single plane x = 0 in clip mode, and an
        // unprimed vertex edges from the origin.
        row.item = mk(1'b1, 32'sd0, 32'sd5, 32'sd6, 1'b0);
        row.n_typed = 1;
        row.typed[0] = '{out_x: 32'sd0, out_y: 32'sd5, out_z: 32'sd6, valid_res: 1'b1,
                         out_index: 6'd0, last_of_run: 1'b1, polygon_done: 1'b0};
        rows.push_back(row);
        // Outside with nothing kept, ending the polygon: one empty marker.
        row.item = mk(1'b1, 32'sd100, 32'sd0, 32'sd0, 1'b1);
        row.n_typed = 1;
        row.typed[0] = '{out_x: 32'sd0, out_y: 32'sd0, out_z: 32'sd0, valid_res: 1'b0,
                         out_index: 6'd1, last_of_run: 1'b1, polygon_done: 1'b1};
        rows.push_back(row);
        row.n_typed = 0;
        // Priming with polygon_end set, which is ignored.
        rows.push_back(dir_row_t'{mk(1'b0, 32'sh7fffffff, 32'sh80000000, 32'sd1, 1'b1), 0,
                                  '{default: '0}});
        rows.push_back(dir_row_t'{mk(1'b1, 32'sh80000000, 32'sh7fffffff, 32'shffffffff, 1'b0),
                                  0, '{default: '0}});
        rows.push_back(dir_row_t'{mk(1'b1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b1),
                                  0, '{default: '0}});
        foreach (rows[i])
        begin
            if (rows[i].n_typed != 0)
            begin
                predict_clip(rows[i].item, res);
                for (int j = 0; j < rows[i].n_typed; j++)
                    expected_q.push_back(rows[i].typed[j]);
                drive_item(rows[i].item, int'($urandom_range(0, 10)));
            end
            else
            begin
                send_vertex(rows[i].item, 1'b0);
            end
        end
        wait_idle();

        // Split mode on y, inverted slab so the upper bound collapses.
        write_reg(psc_pkg::REG_AXIS, 32'd1);
        write_reg(psc_pkg::REG_MODE, 32'd1);
        write_reg(psc_pkg::REG_LOWER, 32'sd256);
        write_reg(psc_pkg::REG_UPPER, -32'sd256);
        send_vertex(mk(1'b0, 32'sd10, -32'sd1000, 32'sd3, 1'b0), 1'b0);
        send_vertex(mk(1'b1, 32'sd50, 32'sd1000, 32'sd9, 1'b0), 1'b0);
        send_vertex(mk(1'b1, -32'sd7, 32'sd256, -32'sd9, 1'b0), 1'b0);
        send_vertex(mk(1'b1, 32'sd1, 32'sh80000000, 32'sd2, 1'b1), 1'b0);
        wait_idle();

        // Axis code three selects z; both bounds crossed.
        write_reg(psc_pkg::REG_AXIS, 32'd3);
        write_reg(psc_pkg::REG_MODE, 32'd0);
        write_reg(psc_pkg::REG_LOWER, -32'sd1000);
        write_reg(psc_pkg::REG_UPPER, 32'sd1000);
        send_vertex(mk(1'b0, 32'sd77, -32'sd55, 32'sh7fffffff, 1'b0), 1'b0);
        send_vertex(mk(1'b1, -32'sd77, 32'sd55, 32'sh80000000, 1'b0), 1'b0);
        send_vertex(mk(1'b1, 32'sh12345678, 32'shedcba987, 32'sd2000, 1'b0), 1'b0);
        send_vertex(mk(1'b1, 32'sd3, 32'sd4, 32'sd1000, 1'b1), 1'b0);
        wait_idle();

        // Counter saturation: a long polygon entirely inside the slab.
        write_reg(psc_pkg::REG_LOWER, 32'sh80000000);
        write_reg(psc_pkg::REG_UPPER, 32'sh7fffffff);
        send_vertex(mk(1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0), 1'b1);
        for (int i = 0; i < 70; i++)
            send_vertex(mk(1'b1, $urandom(), $urandom(), $urandom(), i == 69), 1'b1);
        wait_idle();

        // Random polygons under several settings; mostly well-formed loops,
        // with occasional unprimed or broken ones.
        sent = 0;
        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(psc_pkg::REG_AXIS, $urandom_range(0, 3));
            write_reg(psc_pkg::REG_MODE, $urandom_range(0, 1));
            lo = (phase == 0) ? 32'sh80000000 : $signed($urandom_range(0, 8000)) - 32'sd4000;
            hi = (phase == 1) ? 32'sh7fffffff
                 : (phase == 2) ? lo - 32'sd10 : lo + $signed($urandom_range(0, 3000));
            write_reg(psc_pkg::REG_LOWER, lo);
            write_reg(psc_pkg::REG_UPPER, hi);
            if (phase == 0)
            begin
                lo = -32'sd2000;
                hi = 32'sd2000;
            end
            while (sent < (phase + 1) * 50)
            begin
                nverts = $urandom_range(3, psc_pkg::MAX_VERTS);
                if ($urandom_range(0, 9) != 0)
                    send_vertex(mk(1'b0, rand_coord(lo, hi), rand_coord(lo, hi),
                                   rand_coord(lo, hi), $urandom_range(0, 1)), 1'b0);
                for (int i = 0; i < nverts; i++)
                    send_vertex(mk(1'b1, rand_coord(lo, hi), rand_coord(lo, hi),
                                   rand_coord(lo, hi),
                                   (i == nverts - 1) || ($urandom_range(0, 19) == 0)), 1'b0);
                sent += nverts + 1;
                // Occasionally hold the source until the sink has caught up.
                if ($urandom_range(0, 4) == 0)
                begin
                    src_valid <= 1'b0;
                    @(posedge clk);
                    while (expected_q.size() != 0)
                        @(posedge clk);
                end
            end
            wait_idle();
        end

        if (expected_q.size() != 0)
            report_mismatch("missing", '0, expected_q[0]);

        if (fail_count == 0)
            $display("PASS polygon_slab_clipper");
        else
            $display("FAIL polygon_slab_clipper");
        $finish;
    end

endmodule
